// ===== src/contig_edge_merge_table_assert.svh =====
// Assertion macros for the edge merge table checker
`ifndef CONTIG_EDGE_MERGE_TABLE_ASSERT_SVH
`define CONTIG_EDGE_MERGE_TABLE_ASSERT_SVH
`define CEMT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define CEMT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== src/cemt_pkg.sv =====
// Package: types and constants of the edge merge table
`default_nettype none
package cemt_pkg;
   localparam logic [2:0] ST_INSERTED = 3'd0;
   localparam logic [2:0] ST_MERGED   = 3'd1;
   localparam logic [2:0] ST_CONFIRM  = 3'd2;
   localparam logic [2:0] ST_MISMATCH = 3'd3;
   localparam logic [2:0] ST_IGNORED  = 3'd4;
   localparam logic [2:0] ST_FULL     = 3'd5;
   localparam logic [2:0] ST_PURGED   = 3'd6;
   localparam logic [10:0] COUNT_MAX = 11'd2047;
   localparam logic [31:0] HASH_MUL = 32'h9E3779B1;
   localparam logic [7:0] GAP_TOL_RESET = 8'd2;
   localparam logic CMD_MERGE = 1'b0;
   localparam logic CMD_PURGE = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic [63:0] key;
      logic [1:0]  ends;
      logic        kind;
      logic [31:0] gap;
      logic [15:0] support;
      logic [15:0] aln_len;
      logic [15:0] align_score;
      logic [7:0]  reads;
   } item_type;

   typedef struct packed {
      logic [1:0]  ends;
      logic        kind;
      logic [31:0] gap;
      logic [15:0] support;
      logic [15:0] aln_len;
      logic [15:0] align_score;
      logic [1:0]  flags;
      logic [7:0]  reads;
   } entry_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] support;
      logic [31:0] gap;
      logic        conflict;
      logic [10:0] mis;
      logic [10:0] con;
      logic [10:0] emp;
   } result_type;

   typedef enum logic [3:0] {
      BK_CLEAR, BK_IDLE, BK_HASH, BK_PROBE_RD, BK_PROBE_CHK, BK_DECIDE, BK_WRITE,
      BK_PURGE_RD, BK_PURGE_CHK, BK_OUT
   } back_state_type;
endpackage
`default_nettype wire

// ===== src/cemt_front.sv =====
// Front: accepts items into a two-entry queue
`default_nettype none
module cemt_front (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_stall,
   input  wire cemt_pkg::item_type in_item,
   output logic      q_valid,
   input  wire logic q_take,
   output cemt_pkg::item_type q_item
);
   import cemt_pkg::*;
   item_type   buf_ff [2];
   logic       rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign req_stall = (cnt_ff == 2'd2);
   assign push = req_valid && !req_stall;
   assign pop = q_take && q_valid;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_item = buf_ff[rd_ptr_ff];

   always_comb begin
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= in_item;
      end
   end
endmodule
`default_nettype wire

// ===== src/cemt_back.sv =====
// Back: probes, merges and purges the table
`default_nettype none
module cemt_back #(
   parameter int TABLE_DEPTH = 1024,
   parameter int PROBE_LIMIT = 8
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic [7:0] gap_tol,
   input  wire logic q_valid,
   output logic      q_take,
   input  wire cemt_pkg::item_type q_item,
   output logic      res_valid,
   input  wire logic res_stall,
   output cemt_pkg::result_type res
);
   import cemt_pkg::*;
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int PW = $clog2(PROBE_LIMIT + 1);

   back_state_type state_ff, state_in;
   logic       valid_mem [TABLE_DEPTH];
   entry_type  ent_mem [TABLE_DEPTH];
   logic [63:0] key_mem [TABLE_DEPTH];
   entry_type  rd_ent_ff;
   logic [63:0] rd_key_ff;

   item_type   it_ff;
   logic [AW-1:0] home_ff, addr_ff, addr_in;
   logic [PW-1:0] k_ff, k_in;
   logic       found_ff, found_in, free_ff, free_in;
   logic [AW-1:0] slot_ff, slot_in, free_slot_ff, free_slot_in;
   logic       rd_valid_ff;
   logic       last_ff, last_in;
   logic [10:0] mis_ff, mis_in, con_ff, con_in, emp_ff, emp_in;
   result_type res_ff, res_in;
   result_type out_ff, out_in;
   logic       res_valid_ff, res_valid_in;

   logic       wr_en;
   logic [AW-1:0] wr_addr;
   entry_type  wr_ent;
   logic       wr_key_en;
   logic       clr_en, set_en;
   logic [AW-1:0] rd_addr;

   logic [63:0] hk;
   logic [31:0] h1;
   logic [31:0] hm;
   logic [31:0] hh;
   logic [32:0] dgap;
   logic [32:0] sgap;
   logic [31:0] gsum;
   entry_type  e;
   logic [8:0] rsum;
   logic       gpos;

   always_comb begin
      hk = q_item.key ^ {32'd0, q_item.key[63:32]};
      h1 = hk[31:0] ^ hk[47:16];
      hm = h1 * HASH_MUL;
      hh = hm ^ {15'd0, hm[31:15]};
   end

   assign rd_addr = addr_ff;

   always_ff @(posedge clock) begin
      rd_ent_ff <= ent_mem[rd_addr];
      rd_key_ff <= key_mem[rd_addr];
      rd_valid_ff <= valid_mem[rd_addr];
      if (wr_en) begin
         ent_mem[wr_addr] <= wr_ent;
      end
      if (wr_key_en) begin
         key_mem[wr_addr] <= it_ff.key;
      end
      if (set_en || clr_en) begin
         valid_mem[wr_addr] <= set_en;
      end
   end

   always_comb begin
      e = rd_ent_ff;
      dgap = {it_ff.gap[31], it_ff.gap} - {e.gap[31], e.gap};
      sgap = {it_ff.gap[31], it_ff.gap} + {e.gap[31], e.gap};
      if (sgap[32] != sgap[31]) begin
         gsum = sgap[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         gsum = sgap[31:0];
      end
      rsum = {1'b0, e.reads} + {1'b0, it_ff.reads};
      gpos = !it_ff.gap[31] && (it_ff.gap != 32'd0);
   end

   always_comb begin
      logic [32:0] adiff;
      state_in = state_ff;
      addr_in = addr_ff;
      k_in = k_ff;
      found_in = found_ff;
      free_in = free_ff;
      slot_in = slot_ff;
      free_slot_in = free_slot_ff;
      last_in = last_ff;
      mis_in = mis_ff;
      con_in = con_ff;
      emp_in = emp_ff;
      res_in = res_ff;
      out_in = out_ff;
      res_valid_in = res_valid_ff;
      q_take = 1'b0;
      wr_en = 1'b0;
      wr_key_en = 1'b0;
      wr_addr = slot_ff;
      wr_ent = rd_ent_ff;
      clr_en = 1'b0;
      set_en = 1'b0;
      adiff = dgap[32] ? (33'd0 - dgap) : dgap;
      if (res_valid_ff && !res_stall) begin
         res_valid_in = 1'b0;
      end
      unique case (state_ff)
         BK_CLEAR: begin
            wr_addr = addr_ff;
            clr_en = 1'b1;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == AW'(TABLE_DEPTH - 1)) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (q_valid) begin
               q_take = 1'b1;
               res_in = '0;
               if (q_item.cmd == CMD_PURGE) begin
                  addr_in = '0;
                  mis_in = '0;
                  con_in = '0;
                  emp_in = '0;
                  last_in = 1'b0;
                  state_in = BK_PURGE_RD;
               end else begin
                  state_in = BK_HASH;
               end
            end
         end
         BK_HASH: begin
            addr_in = home_ff;
            k_in = '0;
            found_in = 1'b0;
            free_in = 1'b0;
            state_in = BK_PROBE_RD;
         end
         BK_PROBE_RD: begin
            state_in = BK_PROBE_CHK;
         end
         BK_PROBE_CHK: begin
            if (rd_valid_ff) begin
               if (!found_ff && rd_key_ff == it_ff.key) begin
                  found_in = 1'b1;
                  slot_in = addr_ff;
               end
            end else if (!free_ff) begin
               free_in = 1'b1;
               free_slot_in = addr_ff;
            end
            if (k_ff == PW'(PROBE_LIMIT - 1)) begin
               state_in = BK_DECIDE;
            end else begin
               k_in = k_ff + 1'b1;
               addr_in = addr_ff + 1'b1;
               state_in = BK_PROBE_RD;
            end
         end
         BK_DECIDE: begin
            addr_in = slot_ff;
            if (!found_ff) begin
               if (!free_ff) begin
                  res_in.status = ST_FULL;
                  state_in = BK_OUT;
               end else begin
                  slot_in = free_slot_ff;
                  wr_addr = free_slot_ff;
                  wr_en = 1'b1;
                  wr_key_en = 1'b1;
                  set_en = 1'b1;
                  wr_ent.ends = it_ff.ends;
                  wr_ent.kind = it_ff.kind;
                  wr_ent.gap = it_ff.gap;
                  wr_ent.support = it_ff.support;
                  wr_ent.aln_len = it_ff.aln_len;
                  wr_ent.align_score = it_ff.align_score;
                  wr_ent.flags = 2'b00;
                  wr_ent.reads = it_ff.reads;
                  res_in.status = ST_INSERTED;
                  res_in.support = it_ff.support;
                  res_in.gap = it_ff.gap;
                  res_in.conflict = 1'b0;
                  state_in = BK_OUT;
               end
            end else begin
               state_in = BK_PROBE_RD;
               k_in = '1;
            end
         end
         BK_WRITE: begin
            wr_addr = slot_ff;
            wr_ent = e;
            res_in.support = e.support;
            res_in.gap = e.gap;
            res_in.conflict = e.flags[1];
            if (e.flags[0]) begin
               res_in.status = ST_IGNORED;
            end else if (!e.kind && it_ff.kind) begin
               wr_en = 1'b1;
               if (e.support != 16'hFFFF) wr_ent.support = e.support + 16'd1;
               res_in.support = wr_ent.support;
               res_in.status = ST_CONFIRM;
            end else if (!e.kind && !it_ff.kind && adiff > {25'd0, gap_tol}) begin
               wr_en = 1'b1;
               wr_ent.flags[0] = 1'b1;
               res_in.status = ST_MISMATCH;
            end else begin
               wr_en = 1'b1;
               if (!e.kind && !it_ff.kind && $signed(it_ff.gap) < $signed(e.gap)) begin
                  wr_ent.gap = it_ff.gap;
               end
               if (e.kind && it_ff.kind) wr_ent.gap = gsum;
               if (e.support != 16'hFFFF) wr_ent.support = e.support + 16'd1;
               if (it_ff.aln_len > e.aln_len) wr_ent.aln_len = it_ff.aln_len;
               if (it_ff.align_score > e.align_score) wr_ent.align_score = it_ff.align_score;
               if (e.ends != it_ff.ends) wr_ent.flags[1] = 1'b1;
               if (gpos) wr_ent.reads = rsum[8] ? 8'hFF : rsum[7:0];
               res_in.status = ST_MERGED;
               res_in.support = wr_ent.support;
               res_in.gap = wr_ent.gap;
               res_in.conflict = wr_ent.flags[1];
            end
            state_in = BK_OUT;
         end
         BK_PURGE_RD: begin
            state_in = BK_PURGE_CHK;
            last_in = (addr_ff == AW'(TABLE_DEPTH - 1));
         end
         BK_PURGE_CHK: begin
            wr_addr = addr_ff;
            if (rd_valid_ff) begin
               if (e.flags[0]) begin
                  clr_en = 1'b1;
                  if (mis_ff != COUNT_MAX) mis_in = mis_ff + 11'd1;
               end else if (e.kind && !e.gap[31] && e.gap != 32'd0 && e.reads == 8'd0) begin
                  clr_en = 1'b1;
                  if (emp_ff != COUNT_MAX) emp_in = emp_ff + 11'd1;
               end else if (e.flags[1]) begin
                  if (con_ff != COUNT_MAX) con_in = con_ff + 11'd1;
               end
            end
            if (last_ff) begin
               res_in.status = ST_PURGED;
               res_in.mis = mis_in;
               res_in.con = con_in;
               res_in.emp = emp_in;
               state_in = BK_OUT;
            end else begin
               addr_in = addr_ff + 1'b1;
               state_in = BK_PURGE_RD;
            end
         end
         BK_OUT: begin
            if (!res_valid_ff || !res_stall) begin
               res_valid_in = 1'b1;
               out_in = res_ff;
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
      if (state_ff == BK_PROBE_CHK && k_ff == '1) begin
         state_in = BK_WRITE;
         found_in = found_ff;
         addr_in = addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_CLEAR;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_take) begin
         it_ff <= q_item;
         home_ff <= hh[AW-1:0];
      end
      if (reset) begin
         addr_ff <= '0;
      end else begin
         addr_ff <= addr_in;
      end
      k_ff <= k_in;
      found_ff <= found_in;
      free_ff <= free_in;
      slot_ff <= slot_in;
      free_slot_ff <= free_slot_in;
      last_ff <= last_in;
      mis_ff <= mis_in;
      con_ff <= con_in;
      emp_ff <= emp_in;
      res_ff <= res_in;
      out_ff <= out_in;
   end

   assign res_valid = res_valid_ff;
   assign res = out_ff;
endmodule
`default_nettype wire

// ===== src/contig_edge_merge_table.sv =====
// Edge merge table top level: configuration register, front queue, back engine
// Usage:
//  Input words arrive on req_valid/req_stall; cmd 0 merges an edge, cmd 1 purges.
//  Each input word yields exactly one result word on rsp_valid/rsp_stall.
//  A merge probes PROBE_LIMIT slots, each in a read state and a check state;
//  an insert or a full table then goes to the result, and a hit adds one
//  read-modify-write of the matching slot before its result.
//  A purge reads and checks every table entry in turn.
//  Words are worked one at a time; the back takes a queued word in the cycle
//  rsp_valid rises, and a two-word queue keeps accepting while it is busy.
//  csr_wr_en writes gap_tolerance; write only while the block is idle.
//  Reset (synchronous, active high) sets gap_tolerance to 2, drops queued and
//  pending words and starts a clearing pass that empties every table slot;
//  the queue accepts up to two words meanwhile.
//  While rsp_stall is high the finished result holds and the back stops
//  before presenting the next one; the queue fills and then raises req_stall.
`default_nettype none
module contig_edge_merge_table #(
   parameter int TABLE_DEPTH = 1024,
   parameter int PROBE_LIMIT = 8
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_wr_en,
   input  wire logic [7:0] csr_gap_tolerance,
   input  wire logic req_valid,
   output logic      req_stall,
   input  wire logic req_cmd,
   input  wire logic [31:0] req_cid_high,
   input  wire logic [31:0] req_cid_low,
   input  wire logic req_end_first,
   input  wire logic req_end_second,
   input  wire logic req_kind,
   input  wire logic signed [31:0] req_gap_in,
   input  wire logic [15:0] req_support_in,
   input  wire logic [15:0] req_aln_len_in,
   input  wire logic [15:0] req_align_score_in,
   input  wire logic [7:0] req_read_count_in,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   output logic [2:0] rsp_status,
   output logic [15:0] rsp_support_out,
   output logic signed [31:0] rsp_gap_out,
   output logic      rsp_conflict_out,
   output logic [10:0] rsp_mismatch_removed,
   output logic [10:0] rsp_conflicts_kept,
   output logic [10:0] rsp_empty_spans_removed
);
   import cemt_pkg::*;
   logic [7:0] gap_tol_ff;
   item_type   in_item, q_item;
   logic       q_valid, q_take;
   result_type res;

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_tol_ff <= GAP_TOL_RESET;
      end else if (csr_wr_en) begin
         gap_tol_ff <= csr_gap_tolerance;
      end
   end

   always_comb begin
      in_item.cmd = req_cmd;
      in_item.key = {req_cid_high, req_cid_low};
      in_item.ends = {req_end_second, req_end_first};
      in_item.kind = req_kind;
      in_item.gap = req_gap_in;
      in_item.support = req_support_in;
      in_item.aln_len = req_aln_len_in;
      in_item.align_score = req_align_score_in;
      in_item.reads = req_read_count_in;
   end

   cemt_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .in_item(in_item), .q_valid(q_valid), .q_take(q_take), .q_item(q_item)
   );

   cemt_back #(.TABLE_DEPTH(TABLE_DEPTH), .PROBE_LIMIT(PROBE_LIMIT)) u_back (
      .clock(clock), .reset(reset), .gap_tol(gap_tol_ff), .q_valid(q_valid),
      .q_take(q_take), .q_item(q_item), .res_valid(rsp_valid),
      .res_stall(rsp_stall), .res(res)
   );

   assign rsp_status = res.status;
   assign rsp_support_out = res.support;
   assign rsp_gap_out = res.gap;
   assign rsp_conflict_out = res.conflict;
   assign rsp_mismatch_removed = res.mis;
   assign rsp_conflicts_kept = res.con;
   assign rsp_empty_spans_removed = res.emp;
endmodule
`default_nettype wire

// ===== src/cemt_checker.sv =====
// Port checker for the edge merge table, bound to the top level
`default_nettype none
`include "contig_edge_merge_table_assert.svh"
module cemt_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire logic [2:0] rsp_status,
   input wire logic [15:0] rsp_support_out,
   input wire logic [10:0] rsp_mismatch_removed
);
   import cemt_pkg::*;
   `CEMT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `CEMT_ASSERT_NEXT(a_status_hold, clock, reset, rsp_valid && rsp_stall, $stable(rsp_status))
   `CEMT_ASSERT_IMPL(a_status_range, clock, reset, rsp_valid, rsp_status != 3'd7)
   `CEMT_ASSERT_IMPL(a_full_zero, clock, reset, rsp_valid && rsp_status == ST_FULL,
      rsp_support_out == 16'd0)
   `CEMT_ASSERT_IMPL(a_merge_counts, clock, reset, rsp_valid && rsp_status != ST_PURGED,
      rsp_mismatch_removed == 11'd0)
endmodule
bind contig_edge_merge_table cemt_checker u_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_status(rsp_status), .rsp_support_out(rsp_support_out),
   .rsp_mismatch_removed(rsp_mismatch_removed)
);
`default_nettype wire
